// File: src/mtv_pkg.sv
// Shared types and constants for the third-majority vote block.
package mtv_pkg;

	localparam int VALUE_W = 32;
	localparam int TUSER_W = 2;

	typedef logic [VALUE_W-1:0] value_t;

	// Finished run handed from the front to the back.
	typedef struct packed {
		value_t cand1;
		value_t cand2;
		logic   dropped;
	} job_t;

endpackage

// File: src/majority_third_vote.sv
// Top level of the third-majority vote block: front end, element store and back end.
//
//   channel   dir  data                       side info
//   s_axis    in   tdata[31:0] value          tlast = last element of the run
//   m_axis    out  tdata[31:0] element        tuser[0] found, tuser[1] overflow,
//                                             tlast = final result of the run
//
// The element that ends a run of n stored values starts a rescan of the store,
// one read per cycle through the single read port; the first result is offered
// after the rescan, and a second one, if any, follows once the first is taken.
// New elements wait while a finished run is queued or being rescanned.
// Reset is asynchronous and active low; the store is not cleared. A stalled
// result stalls only the back end; the front keeps loading the next run.
module majority_third_vote import mtv_pkg::*; #(
	parameter int MAX_ITEMS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [VALUE_W-1:0] s_axis_tdata,   // [31:0] value
	input  logic               s_axis_tlast,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [VALUE_W-1:0] m_axis_tdata,   // [31:0] element
	output logic [TUSER_W-1:0] m_axis_tuser,   // [0] found, [1] overflow
	output logic               m_axis_tlast
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	// Store write side, driven by the front end.
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	value_t        wr_data;

	// Store read side, driven by the back end.
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	value_t        rd_data;

	// One-deep request queue between the two halves.
	logic          job_valid, job_pop, scan_busy;
	job_t          job;
	logic [CW-1:0] job_count;

	logic          out_found, out_overflow;

	// Accept elements, keep the running vote, hand over finished runs.
	mtv_front #(.MAX_ITEMS(MAX_ITEMS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_value  (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.scan_busy (scan_busy),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.job_valid (job_valid),
		.job_pop   (job_pop),
		.job       (job),
		.job_count (job_count)
	);

	// Element store: written in arrival order, read back during the rescan.
	mtv_ram #(.WIDTH(VALUE_W), .DEPTH(MAX_ITEMS)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Recount both candidates and drive the result stream.
	mtv_back #(.MAX_ITEMS(MAX_ITEMS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (job_valid),
		.job_pop      (job_pop),
		.job          (job),
		.job_count    (job_count),
		.scan_busy    (scan_busy),
		.rd_en        (rd_en),
		.rd_addr      (rd_addr),
		.rd_data      (rd_data),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_element  (m_axis_tdata),
		.out_found    (out_found),
		.out_final    (m_axis_tlast),
		.out_overflow (out_overflow)
	);

	assign m_axis_tuser = {out_overflow, out_found};

endmodule

// File: src/mtv_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mtv_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// File: src/mtv_front.sv
// Front end: accepts elements, stores them, runs the two-candidate vote, queues finished runs.
module mtv_front import mtv_pkg::*; #(
	parameter int MAX_ITEMS = 1024,
	localparam int CW = $clog2(MAX_ITEMS + 1),
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  value_t        in_value,
	input  logic          in_last,
	input  logic          scan_busy,
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output value_t        wr_data,
	output logic          job_valid,
	input  logic          job_pop,
	output job_t          job,
	output logic [CW-1:0] job_count
);

	value_t        cand1_q, cand2_q, cand1_d, cand2_d;
	logic [CW-1:0] votes1_q, votes2_q, votes1_d, votes2_d;
	logic [CW-1:0] count_q, count_d;
	logic          dropped_q, dropped_d;
	logic          job_valid_q;
	job_t          job_q;
	logic [CW-1:0] job_count_q;
	logic          accept, store_ok;

	assign in_ready = !job_valid_q && !scan_busy;
	assign accept   = in_valid && in_ready;
	assign store_ok = count_q < CW'(MAX_ITEMS);

	assign wr_en   = accept && store_ok;
	assign wr_addr = count_q[AW-1:0];
	assign wr_data = in_value;

	// Run state after this element, before the end-of-run clear.
	always_comb begin
		cand1_d   = cand1_q;
		cand2_d   = cand2_q;
		votes1_d  = votes1_q;
		votes2_d  = votes2_q;
		count_d   = count_q;
		dropped_d = dropped_q;
		if (store_ok) begin
			count_d = count_q + CW'(1);
			priority if (in_value == cand1_q) begin
				votes1_d = votes1_q + CW'(1);
			end else if (in_value == cand2_q) begin
				votes2_d = votes2_q + CW'(1);
			end else if (votes1_q == '0) begin
				cand1_d  = in_value;
				votes1_d = CW'(1);
			end else if (votes2_q == '0) begin
				cand2_d  = in_value;
				votes2_d = CW'(1);
			end else begin
				votes1_d = votes1_q - CW'(1);
				votes2_d = votes2_q - CW'(1);
			end
		end else begin
			dropped_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand1_q     <= '0;
			cand2_q     <= '0;
			votes1_q    <= '0;
			votes2_q    <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
			job_valid_q <= 1'b0;
		end else begin
			if (job_pop) begin
				job_valid_q <= 1'b0;
			end
			if (accept) begin
				if (in_last) begin
					// Hand the run over and clear for the next one.
					job_valid_q <= 1'b1;
					cand1_q     <= '0;
					cand2_q     <= '0;
					votes1_q    <= '0;
					votes2_q    <= '0;
					count_q     <= '0;
					dropped_q   <= 1'b0;
				end else begin
					cand1_q   <= cand1_d;
					cand2_q   <= cand2_d;
					votes1_q  <= votes1_d;
					votes2_q  <= votes2_d;
					count_q   <= count_d;
					dropped_q <= dropped_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_last) begin
			job_q.cand1   <= cand1_d;
			job_q.cand2   <= cand2_d;
			job_q.dropped <= dropped_d;
			job_count_q   <= count_d;
		end
	end

	assign job_valid = job_valid_q;
	assign job       = job_q;
	assign job_count = job_count_q;

endmodule

// File: src/mtv_back.sv
// Back end: rescans the store for a queued run, checks the threshold, emits the results.
module mtv_back import mtv_pkg::*; #(
	parameter int MAX_ITEMS = 1024,
	localparam int CW = $clog2(MAX_ITEMS + 1),
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          job_valid,
	output logic          job_pop,
	input  job_t          job,
	input  logic [CW-1:0] job_count,
	output logic          scan_busy,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr,
	input  value_t        rd_data,
	output logic          out_valid,
	input  logic          out_ready,
	output value_t        out_element,
	output logic          out_found,
	output logic          out_final,
	output logic          out_overflow
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DECIDE = 5'b00100,
		ST_EMIT1  = 5'b01000,
		ST_EMIT2  = 5'b10000
	} state_t;

	state_t        state_q;
	job_t          job_q;
	logic [CW-1:0] len_q, addr_q, n1_q, n2_q;
	logic          rd_valid_s1;
	logic          q1_q, q2_q;
	logic          out_valid_q, out_found_q, out_final_q, out_overflow_q;
	value_t        out_element_q;
	logic          slot_free;
	logic          emit_fire;
	logic [CW+1:0] n1_x3, n2_x3;

	assign job_pop   = (state_q == ST_IDLE) && job_valid;
	assign scan_busy = (state_q == ST_SCAN);
	assign rd_en     = (state_q == ST_SCAN) && (addr_q < len_q);
	assign rd_addr   = addr_q[AW-1:0];
	assign slot_free = !out_valid_q || out_ready;
	assign emit_fire = slot_free && ((state_q == ST_EMIT1) || (state_q == ST_EMIT2));

	// count > floor(len/3) is the same as 3*count > len.
	assign n1_x3 = {1'b0, n1_q, 1'b0} + {2'b00, n1_q};
	assign n2_x3 = {1'b0, n2_q, 1'b0} + {2'b00, n2_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_valid_s1 <= rd_en;
			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (!rd_en && !rd_valid_s1) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= ST_EMIT1;
				end
				ST_EMIT1: begin
					if (slot_free) begin
						state_q <= (q1_q && q2_q) ? ST_EMIT2 : ST_IDLE;
					end
				end
				ST_EMIT2: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_q  <= job;
			len_q  <= job_count;
			addr_q <= '0;
			n1_q   <= '0;
			n2_q   <= '0;
		end
		if (rd_en) begin
			addr_q <= addr_q + CW'(1);
		end
		if (rd_valid_s1) begin
			priority if (rd_data == job_q.cand1) begin
				n1_q <= n1_q + CW'(1);
			end else if (rd_data == job_q.cand2) begin
				n2_q <= n2_q + CW'(1);
			end else begin
				n1_q <= n1_q;
			end
		end
		if (state_q == ST_DECIDE) begin
			q1_q <= n1_x3 > {2'b00, len_q};
			q2_q <= (n2_x3 > {2'b00, len_q}) && (job_q.cand1 != job_q.cand2);
		end
		if (state_q == ST_EMIT1 && slot_free) begin
			out_overflow_q <= job_q.dropped;
			priority if (q1_q) begin
				out_element_q <= job_q.cand1;
				out_found_q   <= 1'b1;
				out_final_q   <= !q2_q;
			end else if (q2_q) begin
				out_element_q <= job_q.cand2;
				out_found_q   <= 1'b1;
				out_final_q   <= 1'b1;
			end else begin
				out_element_q <= '0;
				out_found_q   <= 1'b0;
				out_final_q   <= 1'b1;
			end
		end
		if (state_q == ST_EMIT2 && slot_free) begin
			out_element_q  <= job_q.cand2;
			out_found_q    <= 1'b1;
			out_final_q    <= 1'b1;
			out_overflow_q <= job_q.dropped;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_element  = out_element_q;
	assign out_found    = out_found_q;
	assign out_final    = out_final_q;
	assign out_overflow = out_overflow_q;

endmodule
